// File: rtl/fit_strategy_block_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Fit-strategy block allocator assertion macros
// Shared property forms for the checker: same-cycle and next-cycle implication
// under the synchronous reset.
// ----------------------------------------------------------------------------
`ifndef FIT_STRATEGY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIT_STRATEGY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define FSBA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FSBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/fsba_pkg.sv
// ----------------------------------------------------------------------------
// fsba_pkg
// Types and codes shared by the fit-strategy block allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fsba_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_STRATEGY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCKS   = 2'd1;

   localparam logic [1:0] STRAT_FIRST = 2'd0;
   localparam logic [1:0] STRAT_BEST  = 2'd1;
   localparam logic [1:0] STRAT_WORST = 2'd2;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   localparam logic [1:0] STATUS_LOADED    = 2'd0;
   localparam logic [1:0] STATUS_ALLOCATED = 2'd1;
   localparam logic [1:0] STATUS_REJECTED  = 2'd2;

   localparam logic [5:0] BLOCKS_RESET = 6'd32;

   typedef struct packed {
      logic        req_type;
      logic [4:0]  block_index;
      logic [15:0] amount;
   } fsba_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  chosen_block;
      logic [15:0] remaining_after;
   } fsba_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } fsba_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_acc;
      logic alloc_acc;
      logic scan_rd;
      logic commit;
   } fsba_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic limit_zero;
      logic scan_last;
   } fsba_stat_type;

endpackage

`default_nettype wire

// File: rtl/fsba_ctrl.sv
// ----------------------------------------------------------------------------
// fsba_ctrl
// Sequencer for load, scan, drain and commit of one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module fsba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_is_alloc,
   input  fsba_pkg::fsba_stat_type stat,
   output fsba_pkg::fsba_cmd_type  cmd,
   output logic                   busy,
   output logic                   rsp_valid
);
   import fsba_pkg::*;

   fsba_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_is_alloc) begin
                  cmd.alloc_acc = 1'b1;
                  state_in      = stat.limit_zero ? ST_COMMIT : ST_SCAN;
               end else begin
                  cmd.load_acc = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read data is compared in this cycle
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/fsba_dp.sv
// ----------------------------------------------------------------------------
// fsba_dp
// Capacity memory, settings registers, scan compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsba_dp #(
   parameter int NUM_BLOCKS = 32,
   parameter int SIZE_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fsba_pkg::fsba_req_type               req_data,
   input  fsba_pkg::fsba_cmd_type               cmd,
   input  logic                                 csr_wr,
   input  logic [fsba_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fsba_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output fsba_pkg::fsba_stat_type              stat,
   output fsba_pkg::fsba_rsp_type               rsp_data
);
   import fsba_pkg::*;

   localparam int ADDR_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);

   // settings
   logic [1:0] strategy_ff;
   logic [5:0] blocks_ff;

   // capacity store with per-entry valid bits, invalid reads as zero
   logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
   logic                 valid_ff [NUM_BLOCKS];

   logic [SIZE_BITS-1:0] amt_ff;
   logic [CNT_W-1:0]     addr_ff;
   logic [CNT_W-1:0]     addr_next;
   logic [CNT_W-1:0]     limit;
   logic                 rd_pend_ff;
   logic [ADDR_W-1:0]    rd_idx_ff;
   logic [SIZE_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic                 found_ff;
   logic [SIZE_BITS-1:0] best_cap_ff;
   logic [ADDR_W-1:0]    best_idx_ff;
   fsba_rsp_type         rsp_ff, rsp_in;

   logic [31:0]          amt_w, bi_w, biu_w, rem_w, load_w, idx_w;
   logic [SIZE_BITS-1:0] amt_in, cap, rem_new;
   logic                 in_range, take;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [SIZE_BITS-1:0] wr_data;

   assign amt_w    = 32'(req_data.amount);
   assign amt_in   = amt_w[SIZE_BITS-1:0];
   assign bi_w     = 32'(req_data.block_index);
   assign in_range = (bi_w < 32'(NUM_BLOCKS));
   assign load_w   = 32'(amt_in);

   // saturate the block count to the store depth
   assign biu_w = 32'(blocks_ff);
   always_comb begin
      if (biu_w > 32'(NUM_BLOCKS)) begin
         limit = CNT_W'(NUM_BLOCKS);
      end else begin
         limit = biu_w[CNT_W-1:0];
      end
   end

   assign addr_next       = addr_ff + CNT_W'(1);
   assign stat.limit_zero = (limit == '0);
   assign stat.scan_last  = (addr_next == limit);

   // fit test and strategy compare on the registered read data
   assign cap  = rd_valid_ff ? rd_data_ff : '0;
   assign take = (cap >= amt_ff) &&
                 (!found_ff ||
                  ((strategy_ff == STRAT_BEST) && (cap < best_cap_ff)) ||
                  ((strategy_ff == STRAT_WORST) && (cap > best_cap_ff)));

   assign rem_new = best_cap_ff - amt_ff;
   assign rem_w   = 32'(rem_new);
   assign idx_w   = 32'(best_idx_ff);

   // single write port: loads and commit-time write back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = rem_new;
      if (cmd.load_acc) begin
         wr_en   = in_range;
         wr_addr = bi_w[ADDR_W-1:0];
         wr_data = amt_in;
      end else if (cmd.commit) begin
         wr_en = found_ff;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_acc) begin
         rsp_in.status          = STATUS_LOADED;
         rsp_in.chosen_block    = req_data.block_index;
         rsp_in.remaining_after = in_range ? load_w[15:0] : 16'd0;
      end else if (cmd.commit) begin
         if (found_ff) begin
            rsp_in.status          = STATUS_ALLOCATED;
            rsp_in.chosen_block    = idx_w[4:0];
            rsp_in.remaining_after = rem_w[15:0];
         end else begin
            rsp_in.status          = STATUS_REJECTED;
            rsp_in.chosen_block    = 5'd0;
            rsp_in.remaining_after = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.scan_rd) begin
         rd_data_ff <= mem[addr_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         strategy_ff <= STRAT_FIRST;
         blocks_ff   <= BLOCKS_RESET;
         rd_pend_ff  <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (csr_wr) begin
            if (csr_index == CSR_STRATEGY) begin
               strategy_ff <= csr_wdata[1:0];
            end else if (csr_index == CSR_BLOCKS) begin
               blocks_ff <= csr_wdata[5:0];
            end
         end
         rd_pend_ff <= cmd.scan_rd;
         if (cmd.alloc_acc) begin
            found_ff <= 1'b0;
         end else if (rd_pend_ff && take) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.alloc_acc) begin
         amt_ff  <= amt_in;
         addr_ff <= '0;
      end else if (cmd.scan_rd) begin
         addr_ff <= addr_next;
      end
      if (cmd.scan_rd) begin
         rd_idx_ff   <= addr_ff[ADDR_W-1:0];
         rd_valid_ff <= valid_ff[addr_ff[ADDR_W-1:0]];
      end
      if (rd_pend_ff && take) begin
         best_cap_ff <= cap;
         best_idx_ff <= rd_idx_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/fit_strategy_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// fit_strategy_block_allocator_unit
// First, best and worst fit allocation over a table of block capacities.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. A load
// writes one block's capacity in the accept cycle and its result shows on the
// next cycle; busy stays low, so loads can follow back to back. An allocation
// holds busy through the scan, drain and commit states and registers its
// result on leaving the commit state; the scan reads N blocks, where N is
// blocks_in_use saturated to NUM_BLOCKS. With N zero there is no scan and no
// drain, and busy covers only the commit state. The scan sets the length: the
// capacity memory has one read port and is read once per block in use, then
// a drain state ends the last compare and a commit writes the chosen block back.
// Each result is shown for exactly one cycle with rsp_valid high; the receiver
// cannot stall it, so capture it on that cycle. Capacities read as zero after
// reset through per-block valid bits, so no clearing pass is run. Settings
// are written through the csr port, which is always ready; write them only
// while the unit is idle.
`default_nettype none

module fit_strategy_block_allocator_unit #(
   parameter int NUM_BLOCKS = 32,
   parameter int SIZE_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request transfer
   input  logic                              start,
   output logic                              busy,
   input  fsba_pkg::fsba_req_type            req_data,
   // result transfer
   output logic                              rsp_valid,
   output fsba_pkg::fsba_rsp_type            rsp_data,
   // settings write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fsba_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fsba_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fsba_pkg::*;

   fsba_cmd_type  cmd;
   fsba_stat_type stat;
   logic          req_is_alloc;

   // settings writes are always accepted
   assign csr_ready    = 1'b1;
   assign req_is_alloc = (req_data.req_type == REQ_ALLOC);

   // sequence one request at a time
   fsba_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_is_alloc (req_is_alloc),
      .stat         (stat),
      .cmd          (cmd),
      .busy         (busy),
      .rsp_valid    (rsp_valid)
   );

   // hold capacities, run the fit compare, register the result
   fsba_dp #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_wr    (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/fsba_checker.sv
// ----------------------------------------------------------------------------
// fsba_checker
// Port-level checks on request and result timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fit_strategy_block_allocator_unit_macros.svh"

module fsba_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  fsba_pkg::fsba_req_type req_data,
   input  logic                   rsp_valid,
   input  fsba_pkg::fsba_rsp_type rsp_data
);
   import fsba_pkg::*;

   // an accepted request either answers next cycle or holds busy
   `FSBA_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_valid || busy, "request accepted without progress")

   // end of an allocation always delivers a result
   `FSBA_ASSERT_NOW(a_busy_end_rsp, clock, reset, $fell(busy), rsp_valid, "busy dropped without a result")

   // a load result follows a load accepted the cycle before
   `FSBA_ASSERT_NOW(a_load_origin, clock, reset, rsp_valid && (rsp_data.status == STATUS_LOADED), $past(start && !busy && (req_data.req_type == REQ_LOAD)), "load result without a load transfer")

   // a rejected request reports block zero and no capacity
   `FSBA_ASSERT_NOW(a_reject_zero, clock, reset, rsp_valid && (rsp_data.status == STATUS_REJECTED), (rsp_data.chosen_block == 5'd0) && (rsp_data.remaining_after == 16'd0), "rejected result carries data")

endmodule

bind fit_strategy_block_allocator_unit fsba_checker u_fsba_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
